/* rtl/rch_pkg.sv */
// ---------------------------------------------------------------------------
// Rectangle and circle hit test package
// Shared widths and reset value for the hit test pipeline.
// ---------------------------------------------------------------------------
package rch_pkg;

    localparam int RADIUS_BITS = 15;
    localparam int R2_BITS     = 2 * RADIUS_BITS;
    localparam int R2_HALF     = RADIUS_BITS;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 15'd16;

endpackage

/* rtl/rect_circle_hit_test_top.sv */
// ---------------------------------------------------------------------------
// Rectangle and circle hit test, top level
// Nine-stage pipeline that tests a circle against a quadrilateral.
// ---------------------------------------------------------------------------
// The block accepts one item per clock while the output is not stalled and
// returns its hit flag through the input, difference, product, sum,
// projection range, split square, partial sum, wide compare and hit stages.
// A stall on the output while a result waits there holds every stage in
// place, and the input stall follows it in the same cycle. The user writes
// the radius through cfg_wr_en and cfg_wr_data only while no item is in
// flight; the block does not enforce this. The radius square is registered.
module rect_circle_hit_test_top #(
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        enable,
    input  logic [15:0] corner_a_x,
    input  logic [15:0] corner_a_y,
    input  logic [15:0] corner_b_x,
    input  logic [15:0] corner_b_y,
    input  logic [15:0] corner_c_x,
    input  logic [15:0] corner_c_y,
    input  logic [15:0] corner_d_x,
    input  logic [15:0] corner_d_y,
    input  logic [15:0] centre_x,
    input  logic [15:0] centre_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit
);

    localparam int CB = COORD_BITS;
    localparam int PW = 2 * CB + 2;
    localparam int CW = (PW > rch_pkg::R2_BITS) ? PW : rch_pkg::R2_BITS;

    logic [rch_pkg::RADIUS_BITS-1:0] radius_reg;
    logic [rch_pkg::R2_BITS-1:0]     r2_reg, r2_next;
    logic                            adv;
    logic [9:1]                      v_reg;
    logic [8:1]                      en_reg;
    logic [3:0]                      pin_reg [5:8];
    logic [8:5]                      ang_reg;
    logic                            hit_reg, hit_next;
    logic [15:0]                     raw [10];
    logic signed [CB-1:0]            ext [10];
    logic signed [CB-1:0]            crd_reg [10];
    logic [PW-1:0]                   len2 [4];
    logic [PW-1:0]                   dist2 [4];
    logic signed [PW-1:0]            dotp [4];
    logic signed [PW-1:0]            crossp [4];
    logic [3:0]                      close;
    logic [3:0]                      pin_next;
    logic                            ang_next;

    assign raw[0] = corner_a_x;
    assign raw[1] = corner_a_y;
    assign raw[2] = corner_b_x;
    assign raw[3] = corner_b_y;
    assign raw[4] = corner_c_x;
    assign raw[5] = corner_c_y;
    assign raw[6] = corner_d_x;
    assign raw[7] = corner_d_y;
    assign raw[8] = centre_x;
    assign raw[9] = centre_y;

    for (genvar k = 0; k < 10; k++)
    begin : g_ext
        if (CB <= 16)
        begin : g_narrow
            assign ext[k] = raw[k][CB-1:0];
        end
        else
        begin : g_wide
            assign ext[k] = {{(CB-16){1'b0}}, raw[k]};
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_edge
        rch_edge_arith #(.CB(CB)) u_arith (
            .clk    (clk),
            .adv    (adv),
            .sx     (crd_reg[2*i]),
            .sy     (crd_reg[2*i+1]),
            .ex     (crd_reg[2*((i+1)%4)]),
            .ey     (crd_reg[2*((i+1)%4)+1]),
            .px     (crd_reg[8]),
            .py     (crd_reg[9]),
            .len2   (len2[i]),
            .dotp   (dotp[i]),
            .crossp (crossp[i]),
            .dist2  (dist2[i])
        );

        rch_dist_cmp #(.CB(CB)) u_cmp (
            .clk    (clk),
            .adv    (adv),
            .len2   (len2[i]),
            .dotp   (dotp[i]),
            .crossp (crossp[i]),
            .r2     (r2_reg),
            .close  (close[i])
        );

        assign pin_next[i] = CW'(dist2[i]) < CW'(r2_reg);
    end

    assign adv      = !v_reg[9] || !out_stall;
    assign in_stall = !adv;
    assign ang_next = !crossp[0][PW-1] && !dotp[0][PW-1] && !crossp[2][PW-1] && !dotp[2][PW-1];
    assign hit_next = en_reg[8] && ((|pin_reg[8]) || ang_reg[8] || (|close));
    assign r2_next  = radius_reg * radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= rch_pkg::RADIUS_RESET;
            v_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
            if (adv)
            begin
                v_reg <= {v_reg[8:1], in_valid};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg <= r2_next;
        if (adv)
        begin
            en_reg     <= {en_reg[7:1], enable};
            crd_reg    <= ext;
            pin_reg[5] <= pin_next;
            pin_reg[6] <= pin_reg[5];
            pin_reg[7] <= pin_reg[6];
            pin_reg[8] <= pin_reg[7];
            ang_reg    <= {ang_reg[7:5], ang_next};
            hit_reg    <= hit_next;
        end
    end

    assign out_valid = v_reg[9];
    assign hit       = hit_reg;

    a_r2_tracks : assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cfg_wr_en) |-> r2_reg == r2_next)
        else $error("Radius square does not follow the radius register.");

    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit))
        else $error("Stalled result item changed.");

    a_valid_moves : assert property (@(posedge clk) disable iff (!rst_n)
        adv && v_reg[8] |=> out_valid)
        else $error("Valid bit lost on its way to the output.");

endmodule

/* rtl/rch_edge_arith.sv */
// ---------------------------------------------------------------------------
// Edge arithmetic
// Three stages: differences, products, sums. Gives the squared edge length,
// the dot and cross products of the edge with the centre offset, and the
// squared distance from the edge start to the centre.
// ---------------------------------------------------------------------------
module rch_edge_arith #(
    parameter int CB = 16
) (
    input  logic                     clk,
    input  logic                     adv,
    input  logic signed [CB-1:0]     sx,
    input  logic signed [CB-1:0]     sy,
    input  logic signed [CB-1:0]     ex,
    input  logic signed [CB-1:0]     ey,
    input  logic signed [CB-1:0]     px,
    input  logic signed [CB-1:0]     py,
    output logic [2*CB+1:0]          len2,
    output logic signed [2*CB+1:0]   dotp,
    output logic signed [2*CB+1:0]   crossp,
    output logic [2*CB+1:0]          dist2
);

    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] dx_reg, dy_reg, wx_reg, wy_reg;
    logic signed [PW-1:0] dxdx_reg, dydy_reg, dxwx_reg, dywy_reg;
    logic signed [PW-1:0] dxwy_reg, dywx_reg, wxwx_reg, wywy_reg;
    logic [PW-1:0]        len2_reg, dist2_reg;
    logic signed [PW-1:0] dot_reg, cross_reg;
    logic signed [PW:0]   len2_next, dist2_next, dot_next, cross_next;

    always_comb
    begin
        len2_next  = (PW+1)'(dxdx_reg) + (PW+1)'(dydy_reg);
        dist2_next = (PW+1)'(wxwx_reg) + (PW+1)'(wywy_reg);
        dot_next   = (PW+1)'(dxwx_reg) + (PW+1)'(dywy_reg);
        cross_next = (PW+1)'(dxwy_reg) - (PW+1)'(dywx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg    <= DW'(ex) - DW'(sx);
            dy_reg    <= DW'(ey) - DW'(sy);
            wx_reg    <= DW'(px) - DW'(sx);
            wy_reg    <= DW'(py) - DW'(sy);
            dxdx_reg  <= dx_reg * dx_reg;
            dydy_reg  <= dy_reg * dy_reg;
            dxwx_reg  <= dx_reg * wx_reg;
            dywy_reg  <= dy_reg * wy_reg;
            dxwy_reg  <= dx_reg * wy_reg;
            dywx_reg  <= dy_reg * wx_reg;
            wxwx_reg  <= wx_reg * wx_reg;
            wywy_reg  <= wy_reg * wy_reg;
            len2_reg  <= len2_next[PW-1:0];
            dist2_reg <= dist2_next[PW-1:0];
            dot_reg   <= dot_next[PW-1:0];
            cross_reg <= cross_next[PW-1:0];
        end
    end

    assign len2   = len2_reg;
    assign dist2  = dist2_reg;
    assign dotp   = dot_reg;
    assign crossp = cross_reg;

endmodule

/* rtl/rch_dist_cmp.sv */
// ---------------------------------------------------------------------------
// Edge distance compare
// Four stages: projection range and magnitude, split partial products,
// partial product sums, and the final compare of cross^2 against r^2 * len^2.
// ---------------------------------------------------------------------------
module rch_dist_cmp #(
    parameter int CB = 16
) (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [2*CB+1:0]               len2,
    input  logic signed [2*CB+1:0]        dotp,
    input  logic signed [2*CB+1:0]        crossp,
    input  logic [rch_pkg::R2_BITS-1:0]   r2,
    output logic                          close
);

    localparam int PW = 2 * CB + 2;
    localparam int H  = PW / 2;
    localparam int RH = rch_pkg::R2_HALF;
    localparam int LW = 2 * PW + rch_pkg::R2_BITS;

    logic            mid5_reg, mid6_reg, mid7_reg, close_reg;
    logic [PW-1:0]   acr5_reg, len5_reg;
    logic [2*H-1:0]  chh_reg, chl_reg, cll_reg;
    logic [RH+H-1:0] rhh_reg, rhl_reg, rlh_reg, rll_reg;
    logic [LW-1:0]   lhs_reg, rhs_reg;
    logic            mid_next;
    logic [PW-1:0]   acr_next;
    logic [LW-1:0]   lhs_next, rhs_next;

    always_comb
    begin
        mid_next = (len2 != '0) && !dotp[PW-1] && (dotp != '0) && ($unsigned(dotp) < len2);
        acr_next = crossp[PW-1] ? PW'(-crossp) : PW'(crossp);
        lhs_next = (LW'(chh_reg) << (2 * H)) + (LW'(chl_reg) << (H + 1)) + LW'(cll_reg);
        rhs_next = (LW'(rhh_reg) << (H + RH)) + (LW'(rhl_reg) << RH)
                 + (LW'(rlh_reg) << H) + LW'(rll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mid5_reg  <= mid_next;
            acr5_reg  <= acr_next;
            len5_reg  <= len2;
            mid6_reg  <= mid5_reg;
            chh_reg   <= acr5_reg[PW-1:H] * acr5_reg[PW-1:H];
            chl_reg   <= acr5_reg[PW-1:H] * acr5_reg[H-1:0];
            cll_reg   <= acr5_reg[H-1:0] * acr5_reg[H-1:0];
            rhh_reg   <= r2[2*RH-1:RH] * len5_reg[PW-1:H];
            rhl_reg   <= r2[2*RH-1:RH] * len5_reg[H-1:0];
            rlh_reg   <= r2[RH-1:0] * len5_reg[PW-1:H];
            rll_reg   <= r2[RH-1:0] * len5_reg[H-1:0];
            mid7_reg  <= mid6_reg;
            lhs_reg   <= lhs_next;
            rhs_reg   <= rhs_next;
            close_reg <= mid7_reg && (lhs_reg < rhs_reg);
        end
    end

    assign close = close_reg;

endmodule

/* sim/rect_circle_hit_test_top_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Rectangle and circle hit test, testbench
// Drives corner and centre items through the valid and stall handshake,
// predicts every hit flag with exact integer arithmetic and compares them in
// order, under several radius settings and idle patterns on both sides.
// ---------------------------------------------------------------------------
module rect_circle_hit_test_top_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic        enable;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] px;
        logic [15:0] py;
    } shape_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    shape_item_t drv_item;
    logic        out_valid;
    logic        out_stall;
    logic        hit;

    shape_item_t pending_items[$];
    logic        expected_hits[$];
    logic [rch_pkg::RADIUS_BITS-1:0] radius_q;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;
    int          cycle_count;

    rect_circle_hit_test_top #(
        .COORD_BITS(16)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .enable     (drv_item.enable),
        .corner_a_x (drv_item.ax),
        .corner_a_y (drv_item.ay),
        .corner_b_x (drv_item.bx),
        .corner_b_y (drv_item.by),
        .corner_c_x (drv_item.cx),
        .corner_c_y (drv_item.cy),
        .corner_d_x (drv_item.dx),
        .corner_d_y (drv_item.dy),
        .centre_x   (drv_item.px),
        .centre_y   (drv_item.py),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic corner_within(longint x, longint y, longint px, longint py,
                                           longint r2);
        return ((x - px) * (x - px) + (y - py) * (y - py)) < r2;
    endfunction

    function automatic logic angle_in_quadrant(longint ox, longint oy, longint ex,
                                               longint ey, longint px, longint py);
        longint ux;
        longint uy;
        longint wx;
        longint wy;
        ux = ex - ox;
        uy = ey - oy;
        wx = px - ox;
        wy = py - oy;
        return (ux * wy - uy * wx) >= 0 && (ux * wx + uy * wy) >= 0;
    endfunction

    function automatic logic edge_within(longint x1, longint y1, longint x2, longint y2,
                                         longint px, longint py, longint r2);
        longint ex;
        longint ey;
        longint wx;
        longint wy;
        longint len2;
        longint proj;
        logic signed [127:0] crs;
        ex = x2 - x1;
        ey = y2 - y1;
        wx = px - x1;
        wy = py - y1;
        len2 = ex * ex + ey * ey;
        proj = ex * wx + ey * wy;
        if (len2 == 0 || proj <= 0)
            return corner_within(x1, y1, px, py, r2);
        if (proj >= len2)
            return corner_within(x2, y2, px, py, r2);
        crs = ex * wy - ey * wx;
        return (crs * crs) < (128'(r2) * 128'(len2));
    endfunction

    function automatic logic predict_hit(shape_item_t s, logic [rch_pkg::RADIUS_BITS-1:0] r);
        longint xs[4];
        longint ys[4];
        longint px;
        longint py;
        longint r2;
        logic   h;
        xs[0] = longint'($signed(s.ax));
        ys[0] = longint'($signed(s.ay));
        xs[1] = longint'($signed(s.bx));
        ys[1] = longint'($signed(s.by));
        xs[2] = longint'($signed(s.cx));
        ys[2] = longint'($signed(s.cy));
        xs[3] = longint'($signed(s.dx));
        ys[3] = longint'($signed(s.dy));
        px = longint'($signed(s.px));
        py = longint'($signed(s.py));
        r2 = longint'(r) * longint'(r);
        h = 1'b0;
        if (!s.enable)
            return 1'b0;
        for (int i = 0; i < 4; i++)
            h |= corner_within(xs[i], ys[i], px, py, r2);
        h |= angle_in_quadrant(xs[0], ys[0], xs[1], ys[1], px, py)
            && angle_in_quadrant(xs[2], ys[2], xs[3], ys[3], px, py);
        for (int i = 0; i < 4; i++)
            h |= edge_within(xs[i], ys[i], xs[(i + 1) % 4], ys[(i + 1) % 4], px, py, r2);
        return h;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 400)) - 200);
            3: return 16'($signed($urandom_range(0, 8000)) - 4000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic shape_item_t rand_shape();
        shape_item_t s;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [15:0] w;
        logic [15:0] h;
        s.enable = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) == 0)
        begin
            s.ax = rand_coord();
            s.ay = rand_coord();
            s.bx = rand_coord();
            s.by = rand_coord();
            s.cx = rand_coord();
            s.cy = rand_coord();
            s.dx = rand_coord();
            s.dy = rand_coord();
            s.px = rand_coord();
            s.py = rand_coord();
        end
        else
        begin
            ox = 16'($signed($urandom_range(0, 4000)) - 2000);
            oy = 16'($signed($urandom_range(0, 4000)) - 2000);
            w = 16'($urandom_range(0, 600));
            h = 16'($urandom_range(0, 600));
            s.ax = ox;
            s.ay = oy;
            s.bx = ox + w;
            s.by = oy;
            s.cx = ox + w;
            s.cy = oy + h;
            s.dx = ox;
            s.dy = oy + h;
            s.px = ox + 16'($signed($urandom_range(0, 1400)) - 400);
            s.py = oy + 16'($signed($urandom_range(0, 1400)) - 400);
        end
        return s;
    endfunction

    function automatic shape_item_t box_shape(logic en, int x0, int y0, int x1, int y1,
                                              int px, int py);
        shape_item_t s;
        s.enable = en;
        s.ax = 16'(x0);
        s.ay = 16'(y0);
        s.bx = 16'(x1);
        s.by = 16'(y0);
        s.cx = 16'(x1);
        s.cy = 16'(y1);
        s.dx = 16'(x0);
        s.dy = 16'(y1);
        s.px = 16'(px);
        s.py = 16'(py);
        return s;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_radius(input logic [rch_pkg::RADIUS_BITS-1:0] r);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= r;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        radius_q = r;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_hits.push_back(predict_hit(drv_item, radius_q));
                void'(pending_items.pop_front());
            end
            if ((!in_valid || !in_stall) && pending_items.size() > 0)
            begin
                if (in_valid && !in_stall)
                begin
                    if ($urandom_range(0, 99) < send_idle_pct)
                        in_valid <= 1'b0;
                    else
                    begin
                        in_valid <= 1'b1;
                        drv_item <= pending_items[0];
                    end
                end
                else if ($urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    drv_item <= pending_items[0];
                end
            end
            else if (in_valid && !in_stall)
            begin
                in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hits.size() == 0)
                report_mismatch("result with no item outstanding");
            else if (hit !== expected_hits[0])
            begin
                report_mismatch($sformatf("hit %b, expected %b", hit, expected_hits[0]));
                void'(expected_hits.pop_front());
            end
            else
                void'(expected_hits.pop_front());
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[rect_circle_hit_test_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [rch_pkg::RADIUS_BITS-1:0] radii[5];
        error_count = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        drv_item = '0;
        radius_q = rch_pkg::RADIUS_RESET;
        send_idle_pct = 21;
        recv_idle_pct = 47;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items run under the reset radius first.
        pending_items.push_back(box_shape(1'b0, 0, 0, 100, 100, 50, 50));
        pending_items.push_back(box_shape(1'b1, 0, 0, 100, 100, 50, 50));
        pending_items.push_back(box_shape(1'b1, 0, 0, 100, 100, -10, -10));
        pending_items.push_back(box_shape(1'b1, 0, 0, 100, 100, -16, 50));
        pending_items.push_back(box_shape(1'b1, 0, 0, 100, 100, -15, 50));
        pending_items.push_back(box_shape(1'b1, 0, 0, 100, 100, 300, 300));
        pending_items.push_back(box_shape(1'b1, 5, 5, 5, 5, 10, 10));
        pending_items.push_back(box_shape(1'b1, 5, 5, 5, 5, 100, 100));
        pending_items.push_back(box_shape(1'b1, -32768, -32768, 32767, 32767, 0, 0));
        pending_items.push_back(box_shape(1'b1, -32768, -32768, 32767, 32767,
                                          32767, -32768));
        pending_items.push_back(box_shape(1'b1, 32767, 32767, -32768, -32768,
                                          -32768, 32767));
        pending_items.push_back(box_shape(1'b1, 0, 0, 1000, 1000, 500, 1010));
        pending_items.push_back(box_shape(1'b1, 0, 0, 1000, 1000, 1100, 1100));
        pending_items.push_back(box_shape(1'b1, 1000, 1000, 0, 0, 500, 500));
        wait_idle();

        radii[0] = '0;
        radii[1] = 15'h7fff;
        radii[2] = 15'd1;
        radii[3] = 15'd200;
        radii[4] = 15'd40;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_radius(radii[phase]);
            if (phase == 2)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 21;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase < 2)
                pending_items.push_back(box_shape(1'b1, 0, 0, 100, 100, 50, 50));
            for (int n = 0; n < 330; n++)
                pending_items.push_back(rand_shape());
            wait_idle();
        end

        if (error_count == 0)
            $display("[rect_circle_hit_test_top] OK");
        else
            $display("[rect_circle_hit_test_top] ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/rch_pkg.sv
rtl/rch_edge_arith.sv
rtl/rch_dist_cmp.sv
rtl/rect_circle_hit_test_top.sv
sim/rect_circle_hit_test_top_tb.sv
